// File: hdl/beep_pattern_sequencer_assert.svh
// assertion macros for the checker file
`ifndef BEEP_PATTERN_SEQUENCER_ASSERT_SVH
`define BEEP_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define BPS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("beep pattern sequencer check failed");

// next-cycle implication, off while reset is high
`define BPS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("beep pattern sequencer check failed");

`endif

// File: hdl/bps_pkg.sv
`timescale 1ns / 1ps

package bps_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_BEEP    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;

  // lowest frequency a beep request may ask for
  localparam logic [15:0] MIN_FREQ = 16'd32;

  // sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  // one input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] tone_freq_in;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
    logic [7:0]  repeat_count;
    logic        alarm_flag;
  } bps_in_t;

  // one result item
  typedef struct packed {
    logic        tone_enable;
    logic [15:0] tone_freq_out;
    logic        busy_res;
    logic        accepted;
    logic        alarm_active;
  } bps_out_t;

endpackage

// File: hdl/beep_pattern_sequencer.sv
`timescale 1ns / 1ps

// Beep pattern sequencer: takes one item per cycle on the req channel (tick,
// beep request or alarm release) and returns exactly one result item for
// each, in order, with tone enable and frequency, busy, accepted and alarm
// state as they stand after that item. An item goes through an input
// register and then the state update into the result register, so a result
// is valid once its item has passed the input register and can be taken
// from then on; a new item can be taken every cycle while the result side
// keeps up, and a stalled result holds both stages. Timing counters and
// stored phase lengths are TIME_BITS wide; phase lengths of zero last one tick.
module beep_pattern_sequencer #(
  parameter int TIME_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bps_pkg::bps_in_t  req,
  output logic              res_valid,
  input  logic              res_ready,
  output bps_pkg::bps_out_t res
);

  // input register
  logic              in_vld;
  bps_pkg::bps_in_t  in_q;
  logic              step;

  // sequencer state
  bps_pkg::phase_t       phase, phase_next;
  logic [TIME_BITS-1:0]  elapsed, elapsed_next;
  logic [15:0]           freq_reg, freq_reg_next;
  logic [TIME_BITS-1:0]  on_len, on_len_next;
  logic [TIME_BITS-1:0]  off_len, off_len_next;
  logic [7:0]            repeats_left, repeats_left_next;
  logic                  alarm_latch, alarm_latch_next;
  logic                  took;
  bps_pkg::bps_out_t     res_next;

  // helper values
  logic [TIME_BITS-1:0]  elapsed_inc;
  logic [TIME_BITS-1:0]  on_eff;
  logic [TIME_BITS-1:0]  off_eff;
  logic [7:0]            reps_dec;
  logic                  beep_ok;

  // the item moves on when the result register is free or being emptied
  assign step      = in_vld && (!res_valid || res_ready);
  assign req_ready = !in_vld || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req_ready) begin
      in_vld <= req_valid;
    end
    if (req_valid && req_ready) begin
      in_q <= req;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bps_pkg::PH_IDLE;
      elapsed      <= '0;
      freq_reg     <= '0;
      on_len       <= '0;
      off_len      <= '0;
      repeats_left <= '0;
      alarm_latch  <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      elapsed      <= elapsed_next;
      freq_reg     <= freq_reg_next;
      on_len       <= on_len_next;
      off_len      <= off_len_next;
      repeats_left <= repeats_left_next;
      alarm_latch  <= alarm_latch_next;
    end
  end

  // phase lengths of zero count as one tick
  assign elapsed_inc = elapsed + TIME_BITS'(1);
  assign on_eff      = (on_len == '0) ? TIME_BITS'(1) : on_len;
  assign off_eff     = (off_len == '0) ? TIME_BITS'(1) : off_len;
  assign reps_dec    = (!alarm_latch && repeats_left != 8'd0) ? repeats_left - 8'd1
                                                               : repeats_left;
  assign beep_ok     = !alarm_latch && (in_q.tone_freq_in >= bps_pkg::MIN_FREQ)
                       && (in_q.repeat_count != 8'd0);

  // next state and result
  always_comb begin
    phase_next        = phase;
    elapsed_next      = elapsed;
    freq_reg_next     = freq_reg;
    on_len_next       = on_len;
    off_len_next      = off_len;
    repeats_left_next = repeats_left;
    alarm_latch_next  = alarm_latch;
    took              = 1'b0;

    unique case (in_q.req_type)
      bps_pkg::REQ_TICK: begin
        unique case (phase)
          bps_pkg::PH_ON: begin
            if (elapsed_inc >= on_eff) begin
              phase_next   = bps_pkg::PH_OFF;
              elapsed_next = '0;
            end else begin
              elapsed_next = elapsed_inc;
            end
          end
          bps_pkg::PH_OFF: begin
            if (elapsed_inc >= off_eff) begin
              repeats_left_next = reps_dec;
              elapsed_next      = '0;
              phase_next        = (reps_dec != 8'd0) ? bps_pkg::PH_ON : bps_pkg::PH_IDLE;
            end else begin
              elapsed_next = elapsed_inc;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
      bps_pkg::REQ_BEEP: begin
        if (beep_ok) begin
          freq_reg_next     = in_q.tone_freq_in;
          on_len_next       = TIME_BITS'(in_q.on_ticks);
          off_len_next      = TIME_BITS'(in_q.off_ticks);
          repeats_left_next = in_q.repeat_count;
          alarm_latch_next  = alarm_latch || in_q.alarm_flag;
          phase_next        = bps_pkg::PH_ON;
          elapsed_next      = '0;
          took              = 1'b1;
        end
      end
      bps_pkg::REQ_RELEASE: begin
        alarm_latch_next = 1'b0;
      end
      default: begin
        took = 1'b0;
      end
    endcase

    res_next.tone_enable   = (phase_next == bps_pkg::PH_ON);
    res_next.tone_freq_out = (phase_next == bps_pkg::PH_ON) ? freq_reg_next : 16'd0;
    res_next.busy_res      = (phase_next != bps_pkg::PH_IDLE);
    res_next.accepted      = took;
    res_next.alarm_active  = alarm_latch_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (step) begin
      res <= res_next;
    end
  end

endmodule

// File: hdl/bps_checker.sv
`timescale 1ns / 1ps
`include "beep_pattern_sequencer_assert.svh"

// port-level checks on the result channel
module bps_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input bps_pkg::bps_out_t res
);

  // a stalled result item holds
  `BPS_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

  // a sounding tone always carries a frequency that passed the request check
  `BPS_ASSERT_IMP(a_tone_freq, clk, rst, res_valid && res.tone_enable, res.tone_freq_out >= bps_pkg::MIN_FREQ && res.busy_res)

  // silence drives no frequency
  `BPS_ASSERT_IMP(a_quiet_zero, clk, rst, res_valid && !res.tone_enable, res.tone_freq_out == 16'd0)

  // an accepted request starts in the on phase
  `BPS_ASSERT_IMP(a_accept_on, clk, rst, res_valid && res.accepted, res.tone_enable && res.busy_res)

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// File: bench/tb_beep_pattern_sequencer.sv
`timescale 1ns / 1ps

module tb_beep_pattern_sequencer;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  bps_pkg::bps_in_t  req;
  logic              res_valid;
  logic              res_ready;
  bps_pkg::bps_out_t res;

  beep_pattern_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // sequencer state as the bench sees it
  bps_pkg::phase_t seq_phase;
  logic [15:0]     seq_elapsed;
  logic [15:0]     seq_freq;
  logic [15:0]     seq_on_len;
  logic [15:0]     seq_off_len;
  logic [7:0]      seq_repeats;
  logic            seq_alarm;

  bps_pkg::bps_out_t tone_expected[$];
  int       items_sent;
  int       beeps_taken;
  int       results_checked;
  int       mismatches;
  int       failures;
  bit       steady_stream;
  int       stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // work out the result of one item and advance the bench state
  function automatic bps_pkg::bps_out_t predict_tone(input bps_pkg::bps_in_t it);
    bps_pkg::bps_out_t r;
    logic        took;
    logic [15:0] eff;
    took = 1'b0;
    case (it.req_type)
      bps_pkg::REQ_TICK: begin
        if (seq_phase == bps_pkg::PH_ON) begin
          seq_elapsed = seq_elapsed + 16'd1;
          eff = (seq_on_len == 16'd0) ? 16'd1 : seq_on_len;
          if (seq_elapsed >= eff) begin
            seq_phase   = bps_pkg::PH_OFF;
            seq_elapsed = 16'd0;
          end
        end else if (seq_phase == bps_pkg::PH_OFF) begin
          seq_elapsed = seq_elapsed + 16'd1;
          eff = (seq_off_len == 16'd0) ? 16'd1 : seq_off_len;
          if (seq_elapsed >= eff) begin
            if (!seq_alarm && seq_repeats != 8'd0)
              seq_repeats = seq_repeats - 8'd1;
            seq_elapsed = 16'd0;
            seq_phase   = (seq_repeats != 8'd0) ? bps_pkg::PH_ON : bps_pkg::PH_IDLE;
          end
        end
      end
      bps_pkg::REQ_BEEP: begin
        if (!seq_alarm && it.tone_freq_in >= bps_pkg::MIN_FREQ &&
            it.repeat_count != 8'd0) begin
          seq_freq    = it.tone_freq_in;
          seq_on_len  = it.on_ticks;
          seq_off_len = it.off_ticks;
          seq_repeats = it.repeat_count;
          if (it.alarm_flag)
            seq_alarm = 1'b1;
          seq_phase   = bps_pkg::PH_ON;
          seq_elapsed = 16'd0;
          took        = 1'b1;
        end
      end
      bps_pkg::REQ_RELEASE: seq_alarm = 1'b0;
      default: ;
    endcase
    r.tone_enable   = (seq_phase == bps_pkg::PH_ON);
    r.tone_freq_out = (seq_phase == bps_pkg::PH_ON) ? seq_freq : 16'd0;
    r.busy_res      = (seq_phase != bps_pkg::PH_IDLE);
    r.accepted      = took;
    r.alarm_active  = seq_alarm;
    return r;
  endfunction

  // record accepted items, compare accepted results
  always @(posedge clk) begin
    bps_pkg::bps_out_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        want = predict_tone(req);
        if (want.accepted)
          beeps_taken++;
        tone_expected.push_back(want);
      end
      if (res_valid && res_ready) begin
        if (tone_expected.size() == 0) begin
          failures++;
          $display("unexpected result at %0t", $realtime);
        end else begin
          want = tone_expected.pop_front();
          results_checked++;
          if (res.tone_enable !== want.tone_enable ||
              res.tone_freq_out !== want.tone_freq_out ||
              res.busy_res !== want.busy_res ||
              res.accepted !== want.accepted ||
              res.alarm_active !== want.alarm_active) begin
            mismatches++;
            failures++;
            if (mismatches <= 10)
              $display("mismatch at %0t: ", $realtime,
                       "expected en=%0b f=%0d busy=%0b acc=%0b alarm=%0b, ",
                       want.tone_enable, want.tone_freq_out, want.busy_res,
                       want.accepted, want.alarm_active,
                       "got en=%0b f=%0d busy=%0b acc=%0b alarm=%0b",
                       res.tone_enable, res.tone_freq_out, res.busy_res,
                       res.accepted, res.alarm_active);
          end
        end
      end
    end
  end

  // result side: random stall bursts, none in the final stretch
  initial begin
    res_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else if (!steady_stream && $urandom_range(0, 9) == 0) begin
        res_ready  <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  function automatic bps_pkg::bps_in_t make_req(input logic [1:0] kind,
                                                input logic [15:0] freq,
                                                input logic [15:0] on_t,
                                                input logic [15:0] off_t,
                                                input logic [7:0] reps,
                                                input logic alarm);
    bps_pkg::bps_in_t it;
    it.req_type     = kind;
    it.tone_freq_in = freq;
    it.on_ticks     = on_t;
    it.off_ticks    = off_t;
    it.repeat_count = reps;
    it.alarm_flag   = alarm;
    return it;
  endfunction

  // present one item and hold it until taken
  task automatic send_item(input bps_pkg::bps_in_t it);
    @(negedge clk);
    if (!steady_stream && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    items_sent++;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_tick();
    send_item(make_req(bps_pkg::REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                       8'($urandom), 1'($urandom)));
  endtask

  // hold off until every expected result is back
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tone_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_requests();
    send_tick();
    // low frequency, zero repeats, unused code, release with no latch
    send_item(make_req(bps_pkg::REQ_BEEP, 16'd31, 16'd3, 16'd3, 8'd1, 1'b0));
    send_item(make_req(bps_pkg::REQ_BEEP, 16'hffff, 16'd3, 16'd3, 8'd0, 1'b1));
    send_item(make_req(bps_pkg::REQ_RSVD, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1));
    send_item(make_req(bps_pkg::REQ_RELEASE, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));
    drain_results();
  endtask

  task automatic test_zero_length();
    send_item(make_req(bps_pkg::REQ_BEEP, bps_pkg::MIN_FREQ, 16'd0, 16'd0, 8'd1, 1'b0));
    send_tick();
    send_tick();
    drain_results();
  endtask

  task automatic test_replace_running();
    send_item(make_req(bps_pkg::REQ_BEEP, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b0));
    send_item(make_req(bps_pkg::REQ_BEEP, 16'd1000, 16'd1, 16'd2, 8'd2, 1'b0));
    repeat (6) send_tick();
    drain_results();
  endtask

  task automatic test_alarm_latch();
    send_item(make_req(bps_pkg::REQ_BEEP, 16'd500, 16'd0, 16'd0, 8'd1, 1'b1));
    send_item(make_req(bps_pkg::REQ_BEEP, 16'd40, 16'd2, 16'd2, 8'd3, 1'b0));
    repeat (3) send_tick();
    send_item(make_req(bps_pkg::REQ_RELEASE, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));
    repeat (2) send_tick();
    drain_results();
  endtask

  function automatic bps_pkg::bps_in_t random_request();
    bps_pkg::bps_in_t it;
    int      pick;
    it   = make_req(bps_pkg::REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 70) return it;
    if (pick < 90) begin
      it.req_type = bps_pkg::REQ_BEEP;
      pick = $urandom_range(0, 9);
      if (pick < 8) it.tone_freq_in = 16'($urandom_range(32, 2000));
      else if (pick == 8) it.tone_freq_in = 16'($urandom_range(0, 31));
      if ($urandom_range(0, 9) != 0) it.on_ticks = 16'($urandom_range(0, 6));
      if ($urandom_range(0, 9) != 0) it.off_ticks = 16'($urandom_range(0, 6));
      pick = $urandom_range(0, 19);
      if (pick < 17) it.repeat_count = 8'($urandom_range(1, 4));
      else if (pick == 17) it.repeat_count = 8'd0;
      it.alarm_flag = ($urandom_range(0, 6) == 0);
    end else if (pick < 96) begin
      it.req_type = bps_pkg::REQ_RELEASE;
    end else begin
      it.req_type = bps_pkg::REQ_RSVD;
    end
    return it;
  endfunction

  task automatic test_random_mix(input int count);
    repeat (count) begin
      send_item(random_request());
      if ($urandom_range(0, 299) == 0)
        drain_results();
    end
    drain_results();
  endtask

  task automatic test_steady_stream(input int count);
    steady_stream = 1'b1;
    repeat (count) send_item(random_request());
  endtask

  initial begin
    int wait_cycles;
    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    steady_stream   = 1'b0;
    items_sent      = 0;
    beeps_taken     = 0;
    results_checked = 0;
    mismatches      = 0;
    failures        = 0;
    seq_phase       = bps_pkg::PH_IDLE;
    seq_elapsed     = '0;
    seq_freq        = '0;
    seq_on_len      = '0;
    seq_off_len     = '0;
    seq_repeats     = '0;
    seq_alarm       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_zero_length();
    test_replace_running();
    test_alarm_latch();
    test_random_mix(1130);
    test_steady_stream(200);

    @(negedge clk);
    req_valid <= 1'b0;
    wait_cycles = 0;
    while (tone_expected.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    failures += tone_expected.size();

    $display("run covered %0d items with %0d beep requests taken", items_sent, beeps_taken);
    $display("%0d results compared, %0d mismatched", results_checked, mismatches);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
